@@ rtl/ccw_pkg.sv @@
package ccw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 32;

  // Cursor column must be able to hold SCREEN_WIDTH itself (pending wrap)
  localparam int COL_W = $clog2(SCREEN_WIDTH + 1);
  localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

  localparam logic [COL_W-1:0] LAST_COL_PLUS1 = COL_W'(SCREEN_WIDTH);
  localparam logic [ROW_W-1:0] BOTTOM_ROW     = ROW_W'(SCREEN_HEIGHT - 1);

  // Result field widths
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;

  localparam logic [4:0] BG_TRANSPARENT = 5'd16;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLOR = 8'h03;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] LEAD_C2  = 8'hC2;
  localparam logic [7:0] LEAD_C3  = 8'hC3;
  localparam logic [7:0] FOLLOW_LO = 8'hA0;
  localparam logic [7:0] FOLLOW_HI = 8'hBF;

  typedef enum logic [1:0] {
    CODE_NONE = 2'd0,
    CODE_FG   = 2'd1,
    CODE_BG   = 2'd2
  } code_mode_t;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SCROLL = 1'b1
  } action_t;

  typedef struct packed {
    action_t                action;
    logic [OUT_ROW_W-1:0]   row;
    logic [OUT_COL_W-1:0]   column;
    logic [7:0]             glyph;
    logic [3:0]             ink_color;
    logic [4:0]             paper_color;
    logic                   last;
  } result_t;

  // Front to queue: number of results pushed this cycle and the results
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

@@ rtl/ccw_front.sv @@
module ccw_front
  import ccw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_bit,
  input  logic       accept,
  input  logic [7:0] char_in,
  input  logic [7:0] next_char,
  input  logic [3:0] base_color,
  input  logic       message_start,
  output push_t      push
);

  logic [COL_W-1:0] col_r,  col_nxt;
  logic [ROW_W-1:0] row_r,  row_nxt;
  code_mode_t       mode_r, mode_nxt;
  logic [1:0]       dc_r,   dc_nxt;
  logic [3:0]       cfg_r,  cfg_nxt;
  logic [4:0]       cbg_r,  cbg_nxt;
  logic             fgg_r,  fgg_nxt;
  logic             bgg_r,  bgg_nxt;
  logic [7:0]       lead_r, lead_nxt;

  // Effective state after a message start
  code_mode_t mode_e;
  logic [1:0] dc_e;
  logic [3:0] cfg_e;
  logic [4:0] cbg_e;
  logic       fgg_e, bgg_e;
  logic [7:0] lead_e;

  logic       is_digit, is_follow;
  logic [3:0] digit;
  logic [3:0] acc;
  logic [7:0] glyph;
  logic       do_print;
  result_t    scroll_res, cell_res;

  always_comb begin
    mode_e = message_start ? CODE_NONE : mode_r;
    dc_e   = message_start ? 2'd0 : dc_r;
    cfg_e  = message_start ? 4'd0 : cfg_r;
    cbg_e  = message_start ? BG_TRANSPARENT : cbg_r;
    fgg_e  = message_start ? 1'b0 : fgg_r;
    bgg_e  = message_start ? 1'b0 : bgg_r;
    lead_e = message_start ? 8'd0 : lead_r;
  end

  assign is_digit  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign is_follow = (next_char >= FOLLOW_LO) && (next_char <= FOLLOW_HI);
  assign digit     = 4'(char_in - CH_ZERO);
  // Two-digit value mod 16: only the low four bits survive
  assign acc = 4'(((mode_e == CODE_FG) ? cfg_e : cbg_e[3:0]) * 4'd10 + digit);

  always_comb begin
    scroll_res.action      = ACT_SCROLL;
    scroll_res.row         = OUT_ROW_W'(BOTTOM_ROW);
    scroll_res.column      = '0;
    scroll_res.glyph       = CH_SPACE;
    scroll_res.ink_color   = 4'd0;
    scroll_res.paper_color = BG_TRANSPARENT;
    scroll_res.last        = 1'b0;
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    mode_nxt = mode_r;
    dc_nxt   = dc_r;
    cfg_nxt  = cfg_r;
    cbg_nxt  = cbg_r;
    fgg_nxt  = fgg_r;
    bgg_nxt  = bgg_r;
    lead_nxt = lead_r;
    glyph    = char_in;
    do_print = 1'b0;
    push     = '0;
    cell_res = '0;

    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = cfg_bit ? BOTTOM_ROW : '0;
    end else if (accept) begin
      mode_nxt = mode_e;
      dc_nxt   = dc_e;
      cfg_nxt  = cfg_e;
      cbg_nxt  = cbg_e;
      fgg_nxt  = fgg_e;
      bgg_nxt  = bgg_e;
      lead_nxt = lead_e;

      if (mode_e != CODE_NONE && is_digit && dc_e < 2'd2) begin
        // Absorb a color digit
        if (mode_e == CODE_FG) begin
          cfg_nxt = (dc_e == 2'd0) ? digit : acc;
          fgg_nxt = 1'b1;
        end else begin
          cbg_nxt = (dc_e == 2'd0) ? {1'b0, digit} : {1'b0, acc};
          bgg_nxt = 1'b1;
        end
        dc_nxt = dc_e + 2'd1;
      end else if (mode_e != CODE_NONE && char_in == CH_COMMA) begin
        mode_nxt = CODE_BG;
        dc_nxt   = 2'd0;
      end else begin
        mode_nxt = CODE_NONE;
        if (lead_e != 8'd0) begin
          // Fold the pending lead with this byte
          glyph    = {lead_e[1:0], char_in[5:0]};
          lead_nxt = 8'd0;
          do_print = 1'b1;
        end else if ((char_in == LEAD_C2 || char_in == LEAD_C3) && is_follow) begin
          lead_nxt = char_in;
        end else if (char_in == CH_LF) begin
          col_nxt = '0;
          fgg_nxt = 1'b0;
          bgg_nxt = 1'b0;
          dc_nxt  = 2'd0;
          if (row_r == BOTTOM_ROW) begin
            push.count      = 2'd1;
            push.first      = scroll_res;
            push.first.last = 1'b1;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else if (char_in == CH_CR) begin
          col_nxt = '0;
          fgg_nxt = 1'b0;
          bgg_nxt = 1'b0;
          dc_nxt  = 2'd0;
        end else if (char_in == CH_COLOR) begin
          mode_nxt = CODE_FG;
          dc_nxt   = 2'd0;
          cfg_nxt  = base_color;
          cbg_nxt  = BG_TRANSPARENT;
          fgg_nxt  = 1'b0;
          bgg_nxt  = 1'b0;
        end else begin
          do_print = 1'b1;
        end
      end

      if (do_print) begin
        cell_res.action      = ACT_WRITE;
        cell_res.glyph       = glyph;
        cell_res.ink_color   = fgg_e ? cfg_e : base_color;
        cell_res.paper_color = bgg_e ? cbg_e : BG_TRANSPARENT;
        cell_res.last        = 1'b1;
        if (col_r >= LAST_COL_PLUS1) begin
          // Wrap, scrolling when already on the bottom row
          cell_res.column = '0;
          col_nxt         = COL_W'(1);
          if (row_r == BOTTOM_ROW) begin
            cell_res.row = OUT_ROW_W'(row_r);
            push.count   = 2'd2;
            push.first   = scroll_res;
            push.second  = cell_res;
          end else begin
            cell_res.row = OUT_ROW_W'(row_r + ROW_W'(1));
            row_nxt      = row_r + ROW_W'(1);
            push.count   = 2'd1;
            push.first   = cell_res;
          end
        end else begin
          cell_res.row    = OUT_ROW_W'(row_r);
          cell_res.column = OUT_COL_W'(col_r);
          col_nxt         = col_r + COL_W'(1);
          push.count      = 2'd1;
          push.first      = cell_res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      mode_r <= CODE_NONE;
      dc_r   <= 2'd0;
      cfg_r  <= 4'd0;
      cbg_r  <= BG_TRANSPARENT;
      fgg_r  <= 1'b0;
      bgg_r  <= 1'b0;
      lead_r <= 8'd0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      mode_r <= mode_nxt;
      dc_r   <= dc_nxt;
      cfg_r  <= cfg_nxt;
      cbg_r  <= cbg_nxt;
      fgg_r  <= fgg_nxt;
      bgg_r  <= bgg_nxt;
      lead_r <= lead_nxt;
    end
  end

endmodule

@@ rtl/ccw_queue.sv @@
module ccw_queue
  import ccw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_head
);

  result_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  // Room for the worst case of two results per transaction
  assign room      = cnt_r <= QCNT_W'(QUEUE_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_head  = mem_r[rd_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_nxt  = wr_r + QPTR_W'(push.count);
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_r + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/color_code_text_console_writer.sv @@
// Color-code text console writer.
// Input stream: one message byte per transaction (in_tdata carries the byte,
// the byte after it and the message's base color; in_tuser flags the first
// byte of a message). Output stream: cell writes and scroll-up commands for
// an external character store; out_tlast marks the final result of a byte.
// Config channel: a single bit, start_at_bottom; a write also homes the cursor.
// It is always ready; the user must see that it is written only while the
// block is idle, as the block itself does not enforce this. Results are
// registered in the result queue before they reach out_tvalid. Throughput:
// one input byte per cycle while each byte causes at most one result and the
// receiver keeps up; a byte that wraps on the bottom row causes two results.
// The rate is set by the single output port of the four-entry result queue
// between the parser and the output. Reset (synchronous, rst_n low): cursor
// at column 0 of row 0, no color code, no pending lead, queue empty.
// Receiver stall: results wait in the queue; in_tready drops once fewer than
// two free queue entries remain, so no result is ever dropped.
module color_code_text_console_writer
  import ccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,     // [0] start_at_bottom
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // [7:0] char_in, [15:8] next_char,
                                    // [19:16] base_color, [23:20] zero
  input  logic        in_tuser,     // [0] message_start
  // Output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [4:0] row, [11:5] column, [19:12] glyph,
                                    // [23:20] ink_color, [28:24] paper_color,
                                    // [31:29] zero
  output logic        out_tuser,    // [0] action
  output logic        out_tlast
);

  push_t   push;
  logic    room;
  logic    in_xact;
  result_t head;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign in_xact   = in_tvalid && room;

  // Front: parse the byte, update cursor and color state, form results
  ccw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid),
    .cfg_bit       (cfg_data),
    .accept        (in_xact),
    .char_in       (in_tdata[7:0]),
    .next_char     (in_tdata[15:8]),
    .base_color    (in_tdata[19:16]),
    .message_start (in_tuser),
    .push          (push)
  );

  // Back: hold results until the receiver takes them
  ccw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_head  (head)
  );

  // Pack the head result onto the stream
  assign out_tdata = {3'b000, head.paper_color, head.ink_color, head.glyph,
                      head.column, head.row};
  assign out_tuser = head.action;
  assign out_tlast = head.last;

endmodule
